// ===== rtl/mlfq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared widths, codes and interface structs of the multilevel feedback
// task scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  // default sizing
  localparam int MAX_TASKS_DEF = 32;
  localparam int LEVELS_DEF    = 5;

  // fixed field widths
  localparam int TIME_W = 24;
  localparam int TID_W  = 5;
  localparam int SVC_W  = 16;
  localparam int LVL_W  = 3;

  // action codes
  localparam logic ACT_ADMIT = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // configuration space: byte address, word index in the upper bits
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_QUANTUM_MODE = 1'b0;
  localparam logic QMODE_RESET = 1'b1;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic admit_we;
    logic run_we;
  } tbl_wr_t;

  typedef struct packed {
    logic              busy;
    logic [TID_W-1:0]  task_id;
    logic [LVL_W-1:0]  level;
    logic              finished;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] turnaround;
    logic [SVC_W-1:0]  service;
  } result_t;

endpackage

// ===== rtl/mlfq_level_fifo.sv =====
// ----------------------------------------------------------------------------
// mlfq_level_fifo
// Circular queue of task ids for one priority level, with head peek that
// forwards a push into an empty queue.
// ----------------------------------------------------------------------------
module mlfq_level_fifo #(
  parameter int MAX_TASKS = mlfq_pkg::MAX_TASKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mlfq_pkg::fifo_req_t          req,
  input  logic [$clog2(MAX_TASKS)-1:0] push_id,
  output logic [$clog2(MAX_TASKS)-1:0] head_id,
  output mlfq_pkg::fifo_stat_t         stat
);

  localparam int IDW = $clog2(MAX_TASKS);
  localparam int CW  = $clog2(MAX_TASKS + 1);

  logic [IDW-1:0] mem_r [MAX_TASKS];
  logic [IDW-1:0] head_r, head_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [IDW:0]   tail_sum, tail_wrap;
  logic [IDW-1:0] tail;

  assign tail_sum  = (IDW+1)'(head_r) + (IDW+1)'(count_r);
  assign tail_wrap = (tail_sum >= (IDW+1)'(MAX_TASKS)) ?
                     tail_sum - (IDW+1)'(MAX_TASKS) : tail_sum;
  assign tail      = tail_wrap[IDW-1:0];

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(MAX_TASKS));

  // an empty queue being pushed this cycle shows the pushed id at its head
  assign head_id = stat.empty ? push_id : mem_r[head_r];

  always_comb begin
    head_nxt  = head_r;
    if (req.pop) begin
      head_nxt = (head_r == IDW'(MAX_TASKS - 1)) ? '0 : head_r + 1'b1;
    end
    count_nxt = count_r + CW'(req.push) - CW'(req.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem_r[tail] <= push_id;
    end
  end

endmodule

// ===== rtl/mlfq_task_table.sv =====
// ----------------------------------------------------------------------------
// mlfq_task_table
// Per-task remaining service, original demand and arrival time.
// ----------------------------------------------------------------------------
module mlfq_task_table #(
  parameter int MAX_TASKS = mlfq_pkg::MAX_TASKS_DEF
) (
  input  logic                              clk,
  input  mlfq_pkg::tbl_wr_t                 wr,
  input  logic [$clog2(MAX_TASKS)-1:0]      admit_id,
  input  logic [mlfq_pkg::SVC_W-1:0]        admit_demand,
  input  logic [mlfq_pkg::TIME_W-1:0]       admit_time,
  input  logic [$clog2(MAX_TASKS)-1:0]      run_id,
  input  logic [mlfq_pkg::SVC_W-1:0]        run_rem,
  output logic [mlfq_pkg::SVC_W-1:0]        rd_rem,
  output logic [mlfq_pkg::SVC_W-1:0]        rd_orig,
  output logic [mlfq_pkg::TIME_W-1:0]       rd_arrival
);

  logic [mlfq_pkg::SVC_W-1:0]  rem_r  [MAX_TASKS];
  logic [mlfq_pkg::SVC_W-1:0]  orig_r [MAX_TASKS];
  logic [mlfq_pkg::TIME_W-1:0] arr_r  [MAX_TASKS];

  assign rd_rem     = rem_r[run_id];
  assign rd_orig    = orig_r[run_id];
  assign rd_arrival = arr_r[run_id];

  // admit and tick never share a cycle, so one write port per table
  always_ff @(posedge clk) begin
    if (wr.admit_we) begin
      rem_r[admit_id]  <= admit_demand;
      orig_r[admit_id] <= admit_demand;
      arr_r[admit_id]  <= admit_time;
    end else if (wr.run_we) begin
      rem_r[run_id] <= run_rem;
    end
  end

endmodule

// ===== rtl/multilevel_feedback_task_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// multilevel_feedback_task_scheduler_unit
// Tick-driven multilevel feedback queue scheduler with per-level quanta.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per command. action=admit queues task_id with
//           service_demand at level 0, stamped with the current time; it
//           produces no result. action=tick advances time one unit and
//           always produces exactly one result transaction on out_*.
//   out_* : the task that ran this tick (or an all-zero idle result), plus
//           finish time, turnaround and original demand on completion.
//   APB   : psel/penable/pwrite/paddr/pwdata/prdata/pready, one register,
//           quantum_mode at byte address 0 (reset 1). pready is tied high.
//           Write it only while no tick result is outstanding.
// Timing: a command is fully processed in the cycle it is accepted; results
//   enter out_*, or the skid while out_* is held. One transaction per cycle
//   if not stalled; the limit is the single pass of requeue, level priority
//   pick, task table read and update between input and result register.
// Stalls: a two-entry output stage (result register plus skid) holds
//   results; in_ready drops only while the skid entry is occupied.
// Reset: synchronous, active low. Clears time, queues, running task and the
//   output stage; takes no clearing pass. Task tables are written on admit.
// ----------------------------------------------------------------------------
module multilevel_feedback_task_scheduler_unit #(
  parameter int MAX_TASKS = mlfq_pkg::MAX_TASKS_DEF,
  parameter int LEVELS    = mlfq_pkg::LEVELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // command channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_action,
  input  logic [mlfq_pkg::TID_W-1:0]         in_task_id,
  input  logic [mlfq_pkg::SVC_W-1:0]         in_service_demand,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_busy_res,
  output logic [mlfq_pkg::TID_W-1:0]         out_running_task,
  output logic [mlfq_pkg::LVL_W-1:0]         out_running_level,
  output logic                               out_finished,
  output logic [mlfq_pkg::TIME_W-1:0]        out_finish_time,
  output logic [mlfq_pkg::TIME_W-1:0]        out_turnaround,
  output logic [mlfq_pkg::SVC_W-1:0]         out_service_total,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mlfq_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [mlfq_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [mlfq_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int IDW = $clog2(MAX_TASKS);
  localparam int LIW = $clog2(LEVELS);
  localparam int QW  = LEVELS;          // quantum up to 2^(LEVELS-1)

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic qmode_r;
  logic cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[mlfq_pkg::CFG_ADDR_W-1:2] == mlfq_pkg::REG_QUANTUM_MODE);
  assign prdata  = cfg_hit ? mlfq_pkg::CFG_DATA_W'(qmode_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qmode_r <= mlfq_pkg::QMODE_RESET;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      qmode_r <= pwdata[0];
    end
  end

  // --------------------------------------------------------------------------
  // Scheduler state
  // --------------------------------------------------------------------------
  logic [mlfq_pkg::TIME_W-1:0] time_r, time_nxt;
  logic                        active_valid_r, active_valid_nxt;
  logic [IDW-1:0]              active_task_r, active_task_nxt;
  logic [LIW-1:0]              active_level_r, active_level_nxt;
  logic [QW-1:0]               qused_r, qused_nxt;

  // output stage
  mlfq_pkg::result_t out_r, skid_r, res;
  logic              out_valid_r, skid_valid_r;

  // handshake decode
  logic accept, is_tick, is_admit, id_ok, admit_go;

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign is_tick  = accept && (in_action == mlfq_pkg::ACT_TICK);
  assign is_admit = accept && (in_action == mlfq_pkg::ACT_ADMIT);
  assign id_ok    = (9'(in_task_id) < 9'(MAX_TASKS));

  // --------------------------------------------------------------------------
  // Level queues
  // --------------------------------------------------------------------------
  mlfq_pkg::fifo_req_t  req     [LEVELS];
  mlfq_pkg::fifo_stat_t stat    [LEVELS];
  logic [IDW-1:0]       head_id [LEVELS];
  logic [IDW-1:0]       push_id;
  logic [LEVELS-1:0]    push_v, pop_v;

  for (genvar g = 0; g < LEVELS; g++) begin : g_level
    assign req[g] = '{push: push_v[g], pop: pop_v[g]};

    mlfq_level_fifo #(
      .MAX_TASKS (MAX_TASKS)
    ) u_fifo (
      .clk     (clk),
      .rst_n   (rst_n),
      .req     (req[g]),
      .push_id (push_id),
      .head_id (head_id[g]),
      .stat    (stat[g])
    );
  end

  assign admit_go = is_admit && id_ok && !stat[0].full;
  assign push_id  = is_admit ? IDW'(in_task_id) : active_task_r;

  // --------------------------------------------------------------------------
  // Tick: retire expired quantum, then pick, then run one unit
  // --------------------------------------------------------------------------
  logic [QW-1:0]  quantum;
  logic           expire, still_active, any_wait, requeue;
  logic [LIW-1:0] rq_lvl;
  logic [LEVELS-1:0] nonempty;
  logic           found, sel_go, running, done;
  logic [LIW-1:0] sel_lvl, run_level;
  logic [IDW-1:0] run_task;

  logic [mlfq_pkg::SVC_W-1:0]  rd_rem, rd_orig, rem_new;
  logic [mlfq_pkg::TIME_W-1:0] rd_arrival, time_inc;

  assign quantum      = qmode_r ? (QW'(1) << active_level_r) : QW'(1);
  assign expire       = active_valid_r && (qused_r >= quantum);
  assign still_active = active_valid_r && !expire;

  // demotion only when someone else is waiting, capped at the lowest level
  always_comb begin
    any_wait = 1'b0;
    for (int l = 0; l < LEVELS; l++) begin
      any_wait = any_wait || !stat[l].empty;
    end
  end

  assign rq_lvl  = (any_wait && active_level_r != LIW'(LEVELS - 1)) ?
                   active_level_r + 1'b1 : active_level_r;
  // a requeue into a full level is dropped
  assign requeue = is_tick && expire && !stat[rq_lvl].full;

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      push_v[l]   = ((l == 0) && admit_go) || (requeue && rq_lvl == LIW'(l));
      nonempty[l] = !stat[l].empty || push_v[l];
    end
  end

  // highest non-empty level wins
  always_comb begin
    found   = 1'b0;
    sel_lvl = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (!found && nonempty[l]) begin
        found   = 1'b1;
        sel_lvl = LIW'(l);
      end
    end
  end

  assign sel_go = is_tick && !still_active && found;

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      pop_v[l] = sel_go && (sel_lvl == LIW'(l));
    end
  end

  assign running   = is_tick && (still_active || found);
  assign run_task  = still_active ? active_task_r : head_id[sel_lvl];
  assign run_level = still_active ? active_level_r : sel_lvl;

  mlfq_pkg::tbl_wr_t tbl_wr;
  assign tbl_wr.admit_we = admit_go;
  assign tbl_wr.run_we   = running;

  mlfq_task_table #(
    .MAX_TASKS (MAX_TASKS)
  ) u_table (
    .clk          (clk),
    .wr           (tbl_wr),
    .admit_id     (IDW'(in_task_id)),
    .admit_demand (in_service_demand),
    .admit_time   (time_r),
    .run_id       (run_task),
    .run_rem      (rem_new),
    .rd_rem       (rd_rem),
    .rd_orig      (rd_orig),
    .rd_arrival   (rd_arrival)
  );

  // a task with no service left completes on the tick it runs
  assign rem_new  = (rd_rem != '0) ? rd_rem - 1'b1 : '0;
  assign done     = (rem_new == '0);
  assign time_inc = time_r + 1'b1;

  always_comb begin
    time_nxt         = time_r;
    active_valid_nxt = active_valid_r;
    active_task_nxt  = active_task_r;
    active_level_nxt = active_level_r;
    qused_nxt        = qused_r;
    if (is_tick) begin
      time_nxt         = time_inc;
      active_valid_nxt = running && !done;
      if (sel_go) begin
        active_task_nxt  = head_id[sel_lvl];
        active_level_nxt = sel_lvl;
      end
      if (running) begin
        qused_nxt = (still_active ? qused_r : '0) + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r         <= '0;
      active_valid_r <= 1'b0;
      active_task_r  <= '0;
      active_level_r <= '0;
      qused_r        <= '0;
    end else begin
      time_r         <= time_nxt;
      active_valid_r <= active_valid_nxt;
      active_task_r  <= active_task_nxt;
      active_level_r <= active_level_nxt;
      qused_r        <= qused_nxt;
    end
  end

  // result of this tick; idle ticks give all zero fields
  always_comb begin
    res.busy        = running;
    res.task_id     = running ? mlfq_pkg::TID_W'(run_task) : '0;
    res.level       = running ? mlfq_pkg::LVL_W'(run_level) : '0;
    res.finished    = running && done;
    res.finish_time = res.finished ? time_inc : '0;
    res.turnaround  = res.finished ? time_inc - rd_arrival : '0;
    res.service     = res.finished ? rd_orig : '0;
  end

  // --------------------------------------------------------------------------
  // Output register with skid entry
  // --------------------------------------------------------------------------
  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || is_tick;
      skid_valid_r <= 1'b0;
    end else if (is_tick) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (is_tick) begin
      skid_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_busy_res      = out_r.busy;
  assign out_running_task  = out_r.task_id;
  assign out_running_level = out_r.level;
  assign out_finished      = out_r.finished;
  assign out_finish_time   = out_r.finish_time;
  assign out_turnaround    = out_r.turnaround;
  assign out_service_total = out_r.service;

`ifndef SYNTHESIS
  // skid only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty output register");

  // completion only reported for a task that ran
  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.finished) |-> out_r.busy)
    else $error("finished without busy");

  // idle tick reports nothing
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.busy) |-> (out_r.task_id == '0 && out_r.service == '0))
    else $error("idle result carries task data");

  // every accepted tick advances time by one
  a_tick_time: assert property (@(posedge clk) disable iff (!rst_n)
    is_tick |=> (time_r == $past(time_inc)))
    else $error("time did not advance on tick");
`endif

endmodule

// ===== tb/multilevel_feedback_task_scheduler_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multilevel_feedback_task_scheduler_unit_tb
// Self-checking bench for the multilevel feedback scheduler. A behavioral
// copy of the scheduler predicts every tick result; a monitor matches the
// results in order, field by field. Directed tests, overflow and stall
// tests, then random admit/tick traffic under both quantum modes.
// ----------------------------------------------------------------------------
module multilevel_feedback_task_scheduler_unit_tb;

  localparam int NTASK = mlfq_pkg::MAX_TASKS_DEF;
  localparam int NLVL  = mlfq_pkg::LEVELS_DEF;
  localparam logic [mlfq_pkg::CFG_ADDR_W-1:0] QMODE_ADDR =
    {mlfq_pkg::REG_QUANTUM_MODE, 2'b00};
  // generous cap on the whole run time, in ns
  localparam int RUN_LIMIT_NS = 1_000_000;
  localparam int DRAIN_GUARD  = 20000;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic                            in_action;
  logic [mlfq_pkg::TID_W-1:0]      in_task_id;
  logic [mlfq_pkg::SVC_W-1:0]      in_service_demand;
  logic                            out_valid;
  logic                            out_ready;
  logic                            out_busy_res;
  logic [mlfq_pkg::TID_W-1:0]      out_running_task;
  logic [mlfq_pkg::LVL_W-1:0]      out_running_level;
  logic                            out_finished;
  logic [mlfq_pkg::TIME_W-1:0]     out_finish_time;
  logic [mlfq_pkg::TIME_W-1:0]     out_turnaround;
  logic [mlfq_pkg::SVC_W-1:0]      out_service_total;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [mlfq_pkg::CFG_ADDR_W-1:0] paddr;
  logic [mlfq_pkg::CFG_DATA_W-1:0] pwdata;
  logic [mlfq_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  // idle percentages for each side, changed per phase
  int src_idle_pct;
  int rcv_idle_pct;
  // when nonzero the receiver parks out_ready low until it counts down to zero
  int rx_hold_cycles = 0;
  int err_count = 0;

  multilevel_feedback_task_scheduler_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_task_id        (in_task_id),
    .in_service_demand (in_service_demand),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_busy_res      (out_busy_res),
    .out_running_task  (out_running_task),
    .out_running_level (out_running_level),
    .out_finished      (out_finished),
    .out_finish_time   (out_finish_time),
    .out_turnaround    (out_turnaround),
    .out_service_total (out_service_total),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scheduler predictor: own copy of time, level queues, task tables and the
  // running slot. Every accepted tick pushes one expected result.
  // --------------------------------------------------------------------------
  logic                            model_qmode;
  logic [mlfq_pkg::TIME_W-1:0]     sched_time;
  logic [mlfq_pkg::TID_W-1:0]      lvl_slots [NLVL][NTASK];
  int                              lvl_head  [NLVL];
  int                              lvl_count [NLVL];
  int                              n_waiting;
  logic [mlfq_pkg::SVC_W-1:0]      svc_left  [NTASK];
  logic [mlfq_pkg::SVC_W-1:0]      svc_orig  [NTASK];
  logic [mlfq_pkg::TIME_W-1:0]     task_arrival [NTASK];
  logic                            run_valid;
  logic [mlfq_pkg::TID_W-1:0]      run_task;
  logic [mlfq_pkg::LVL_W-1:0]      run_level;
  int                              run_used;

  mlfq_pkg::result_t pending_tick_results [$];

  function automatic void predict_reset();
    model_qmode = mlfq_pkg::QMODE_RESET;
    sched_time  = '0;
    n_waiting   = 0;
    for (int l = 0; l < NLVL; l++) begin
      lvl_head[l]  = 0;
      lvl_count[l] = 0;
    end
    for (int t = 0; t < NTASK; t++) begin
      svc_left[t]     = '0;
      svc_orig[t]     = '0;
      task_arrival[t] = '0;
    end
    run_valid = 1'b0;
    run_task  = '0;
    run_level = '0;
    run_used  = 0;
  endfunction

  // tail insert; a full level refuses the task
  function automatic bit lvl_enqueue(int l, logic [mlfq_pkg::TID_W-1:0] id);
    if (lvl_count[l] >= NTASK) return 1'b0;
    lvl_slots[l][(lvl_head[l] + lvl_count[l]) % NTASK] = id;
    lvl_count[l]++;
    n_waiting++;
    return 1'b1;
  endfunction

  function automatic void predict_schedule(logic act, logic [mlfq_pkg::TID_W-1:0] id,
                                           logic [mlfq_pkg::SVC_W-1:0] dem);
    mlfq_pkg::result_t r;
    int                dest;
    if (act == mlfq_pkg::ACT_ADMIT) begin
      // level 0 full: admit dropped, tables untouched
      if (lvl_enqueue(0, id)) begin
        svc_left[id]     = dem;
        svc_orig[id]     = dem;
        task_arrival[id] = sched_time;
      end
      return;
    end
    r = '0;
    // quantum used up: requeue, one level down only if someone else waits
    if (run_valid && run_used >= (model_qmode ? (1 << run_level) : 1)) begin
      dest = run_level;
      if (n_waiting > 0 && dest + 1 < NLVL) dest++;
      void'(lvl_enqueue(dest, run_task));
      run_valid = 1'b0;
    end
    if (!run_valid) begin
      for (int l = 0; l < NLVL; l++) begin
        if (!run_valid && lvl_count[l] > 0) begin
          run_task     = lvl_slots[l][lvl_head[l]];
          lvl_head[l]  = (lvl_head[l] + 1) % NTASK;
          lvl_count[l]--;
          n_waiting--;
          run_level = mlfq_pkg::LVL_W'(l);
          run_used  = 0;
          run_valid = 1'b1;
        end
      end
    end
    sched_time = sched_time + 1'b1;
    if (run_valid) begin
      if (svc_left[run_task] != 0) svc_left[run_task]--;
      run_used++;
      r.busy    = 1'b1;
      r.task_id = run_task;
      r.level   = run_level;
      if (svc_left[run_task] == 0) begin
        r.finished    = 1'b1;
        r.finish_time = sched_time;
        r.turnaround  = sched_time - task_arrival[run_task];
        r.service     = svc_orig[run_task];
        run_valid     = 1'b0;
      end
    end
    pending_tick_results.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Result monitor and receiver
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    mlfq_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_tick_results.size() == 0) begin
        $error("result transaction with no tick outstanding");
        err_count++;
      end else begin
        want = pending_tick_results.pop_front();
        check_field("busy_res",      want.busy,        out_busy_res);
        check_field("running_task",  want.task_id,     out_running_task);
        check_field("running_level", want.level,       out_running_level);
        check_field("finished",      want.finished,    out_finished);
        check_field("finish_time",   want.finish_time, out_finish_time);
        check_field("turnaround",    want.turnaround,  out_turnaround);
        check_field("service_total", want.service,     out_service_total);
      end
    end
  end

  // random stalls, or a long park when a test asks for one
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        while (rx_hold_cycles > 0) begin
          @(posedge clk);
          rx_hold_cycles--;
        end
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------
  // Valid stays up across back-to-back transactions; only a gap lowers it.
  task automatic send_cmd(logic act, logic [mlfq_pkg::TID_W-1:0] id,
                          logic [mlfq_pkg::SVC_W-1:0] dem);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_action         <= act;
    in_task_id        <= id;
    in_service_demand <= dem;
    do @(posedge clk); while (!in_ready);
    predict_schedule(act, id, dem);
  endtask

  task automatic admit(logic [mlfq_pkg::TID_W-1:0] id, logic [mlfq_pkg::SVC_W-1:0] dem);
    send_cmd(mlfq_pkg::ACT_ADMIT, id, dem);
  endtask

  // id and demand are don't-care on a tick, so scramble them
  task automatic tick();
    send_cmd(mlfq_pkg::ACT_TICK, mlfq_pkg::TID_W'($urandom), mlfq_pkg::SVC_W'($urandom));
  endtask

  // Stop sending, let every tick result come home, then idle the clock so that
  // any trailing admit has finished.
  task automatic wait_quiet();
    int guard = 0;
    in_valid <= 1'b0;
    while (pending_tick_results.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    if (pending_tick_results.size() != 0) begin
      $error("%0d tick results never arrived", pending_tick_results.size());
      err_count++;
      pending_tick_results.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  task automatic apb_xfer(input logic wr, input logic [mlfq_pkg::CFG_ADDR_W-1:0] addr,
                          input logic [mlfq_pkg::CFG_DATA_W-1:0] wdata,
                          output logic [mlfq_pkg::CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // only while idle; read back what was written
  task automatic cfg_set_qmode(logic mode);
    logic [mlfq_pkg::CFG_DATA_W-1:0] rd;
    wait_quiet();
    apb_xfer(1'b1, QMODE_ADDR, {{(mlfq_pkg::CFG_DATA_W-1){1'b0}}, mode}, rd);
    model_qmode = mode;
    apb_xfer(1'b0, QMODE_ADDR, '0, rd);
    check_field("quantum_mode", mode, rd);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_config_reset_value();
    logic [mlfq_pkg::CFG_DATA_W-1:0] rd;
    apb_xfer(1'b0, QMODE_ADDR, '0, rd);
    check_field("quantum_mode", mlfq_pkg::QMODE_RESET, rd);
  endtask

  // doubling quanta (reset mode)
  task automatic test_directed_tasks();
    tick();                         // empty scheduler: all-zero result
    admit(0, 1);
    tick();                         // single-tick job
    admit(31, 3);
    admit(5, 0);                    // zero demand completes on its first tick
    repeat (5) tick();              // 31 expires at level 0 and drops
    admit(7, 2);
    admit(7, 2);                    // duplicate id: queued twice
    repeat (4) tick();
    admit(18, 16'hFFFF);
    repeat (2) tick();
    admit(18, 1);                   // overwrite a live task's tables
    repeat (4) tick();
    wait_quiet();
  endtask

  // one-tick quanta: walk down the levels, and a lone task that
  // expires with nobody waiting stays where it is
  task automatic test_level_descent();
    cfg_set_qmode(1'b0);
    admit(9, 6);
    admit(10, 3);
    repeat (12) tick();
    wait_quiet();
  endtask

  // fill level 0, then push enough expired tasks into level 1 that it
  // overflows and requeued tasks are lost
  task automatic test_level_overflow();
    for (int i = 0; i < NTASK; i++) admit(mlfq_pkg::TID_W'(i), 2);
    admit(3, 2);                    // level 0 full: ignored
    repeat (NTASK) tick();
    admit(20, 2);
    tick();
    admit(21, 2);
    repeat (NTASK + 4) tick();
    wait_quiet();
  endtask

  // park the receiver while ticks keep coming so the output stage fills
  // and in_ready drops; then a sender pause until everything is back
  task automatic test_backpressure();
    int saved_src;
    saved_src = src_idle_pct;
    src_idle_pct = 0;
    for (int i = 0; i < 6; i++) admit(mlfq_pkg::TID_W'(i + 11), 3);
    rx_hold_cycles = 80;
    repeat (30) tick();
    wait_quiet();
    admit(2, 4);
    repeat (8) tick();
    src_idle_pct = saved_src;
    wait_quiet();
  endtask

  // mostly short jobs, occasional full-range or zero demand
  task automatic test_random_traffic(int n_items);
    int                         pick;
    logic [mlfq_pkg::SVC_W-1:0] dem;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if (pick < 2) dem = '0;
        else if (pick < 4) dem = mlfq_pkg::SVC_W'($urandom);
        else dem = mlfq_pkg::SVC_W'($urandom_range(24, 1));
        admit(mlfq_pkg::TID_W'($urandom_range(NTASK - 1)), dem);
      end else begin
        tick();
      end
    end
    wait_quiet();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_action         = mlfq_pkg::ACT_TICK;
    in_task_id        = '0;
    in_service_demand = '0;
    out_ready         = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    src_idle_pct      = 30;
    rcv_idle_pct      = 85;
    predict_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase 1: sender idles a little, receiver a lot
    test_config_reset_value();
    test_directed_tasks();
    test_level_descent();
    test_level_overflow();
    test_backpressure();
    cfg_set_qmode(1'b1);
    test_random_traffic(130);

    // phase 2: the other way round
    src_idle_pct = 85;
    rcv_idle_pct = 30;
    cfg_set_qmode(1'b0);
    test_random_traffic(130);

    // phase 3: full rate both sides
    src_idle_pct = 0;
    rcv_idle_pct = 0;
    cfg_set_qmode(1'b1);
    test_random_traffic(70);
    cfg_set_qmode(1'b0);
    test_random_traffic(70);

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("[multilevel_feedback_task_scheduler_unit] OK");
    end else begin
      $display("[multilevel_feedback_task_scheduler_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("[multilevel_feedback_task_scheduler_unit] ERROR");
    $finish;
  end

endmodule
